// ----- rtl/core/sft_pkg.sv -----
// Shared types, character constants and helper functions of the scene file tokenizer.
package sft_pkg;

  localparam int unsigned Q_DEPTH = 4;

  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd1;
  localparam logic [2:0] ERR_NEWLINE      = 3'd2;
  localparam logic [2:0] ERR_TRAIL_ESCAPE = 3'd3;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       token_first;
    logic       token_last;
    logic       byte_valid;
    logic [2:0] error_code;
    logic       run_last;
  } out_item_t;

  // One accepted request's worth of results: one or two.
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_space(c) || (c == CH_DQUOTE) || (c == CH_LBRACKET) || (c == CH_RBRACKET);
  endfunction

  // Returns {legal, decoded byte}.
  function automatic logic [8:0] decode_escape(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    unique case (c)
      CH_LOW_B:     r = {1'b1, CH_BS};
      CH_LOW_F:     r = {1'b1, CH_FF};
      CH_LOW_N:     r = {1'b1, CH_LF};
      CH_LOW_R:     r = {1'b1, CH_CR};
      CH_LOW_T:     r = {1'b1, CH_TAB};
      CH_BACKSLASH: r = {1'b1, c};
      CH_SQUOTE:    r = {1'b1, c};
      CH_DQUOTE:    r = {1'b1, c};
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic out_item_t mk_res(input logic [7:0] b, input logic f, input logic l,
                                       input logic v, input logic [2:0] e);
    out_item_t r;
    r.tok_byte    = b;
    r.token_first = f;
    r.token_last  = l;
    r.byte_valid  = v;
    r.error_code  = e;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/core/sft_front.sv -----
// Front end: accepts characters, runs the lexer mode machine and builds result plans.
module sft_front
  import sft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  q_status_t q_stat,
  output logic      push,
  output plan_t     push_plan
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_WORD    = 3'd2,
    M_QUOTE   = 3'd3,
    M_ESC     = 3'd4,
    M_HALT    = 3'd5
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       held_first_r, held_first_nxt;

  logic [7:0] c;
  logic       accept;

  // Outcome of a character seen between tokens.
  logic       sc_emit;
  out_item_t  sc_res;
  mode_t      sc_mode;
  logic       sc_hold;

  logic [8:0] dec;
  logic [1:0] n;
  out_item_t  r0, r1;

  assign c        = in_data.in_byte;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign dec      = decode_escape(c);

  always_comb begin
    sc_emit = 1'b0;
    sc_res  = '0;
    sc_mode = M_IDLE;
    sc_hold = 1'b0;
    priority if (is_space(c)) begin
      sc_mode = M_IDLE;
    end else if (c == CH_DQUOTE) begin
      sc_emit = 1'b1;
      sc_res  = mk_res(c, 1'b1, 1'b0, 1'b1, ERR_NONE);
      sc_mode = M_QUOTE;
    end else if (c == CH_LBRACKET || c == CH_RBRACKET) begin
      sc_emit = 1'b1;
      sc_res  = mk_res(c, 1'b1, 1'b1, 1'b1, ERR_NONE);
    end else if (c == CH_HASH) begin
      sc_mode = M_COMMENT;
    end else begin
      sc_mode = M_WORD;
      sc_hold = 1'b1;
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;

    if (mode_r == M_HALT) begin
      n = 2'd0;
    end else if (in_data.end_of_input) begin
      if (mode_r == M_QUOTE || mode_r == M_ESC) begin
        mode_nxt       = M_HALT;
        held_valid_nxt = 1'b0;
        r0 = mk_res(8'd0, 1'b0, 1'b0, 1'b0,
                    (mode_r == M_QUOTE) ? ERR_UNTERMINATED : ERR_TRAIL_ESCAPE);
        n  = 2'd1;
      end else begin
        if (mode_r == M_WORD && held_valid_r) begin
          r0 = mk_res(held_byte_r, held_first_r, 1'b1, 1'b1, ERR_NONE);
          n  = 2'd1;
        end
        mode_nxt       = M_IDLE;
        held_valid_nxt = 1'b0;
        held_first_nxt = 1'b0;
      end
    end else begin
      unique case (mode_r)
        M_COMMENT: begin
          if (c == CH_CR || c == CH_LF) mode_nxt = M_IDLE;
        end
        M_WORD: begin
          if (is_delim(c)) begin
            // The held byte closes the word, then the delimiter starts afresh.
            if (held_valid_r) begin
              r0 = mk_res(held_byte_r, held_first_r, 1'b1, 1'b1, ERR_NONE);
              r1 = sc_res;
              n  = sc_emit ? 2'd2 : 2'd1;
            end else begin
              r0 = sc_res;
              n  = sc_emit ? 2'd1 : 2'd0;
            end
            mode_nxt       = sc_mode;
            held_valid_nxt = sc_hold;
            held_first_nxt = sc_hold;
            if (sc_hold) held_byte_nxt = c;
          end else begin
            if (held_valid_r) begin
              r0 = mk_res(held_byte_r, held_first_r, 1'b0, 1'b1, ERR_NONE);
              n  = 2'd1;
            end
            held_byte_nxt  = c;
            held_valid_nxt = 1'b1;
            held_first_nxt = 1'b0;
          end
        end
        M_QUOTE: begin
          if (c == CH_LF) begin
            mode_nxt       = M_HALT;
            held_valid_nxt = 1'b0;
            r0 = mk_res(8'd0, 1'b0, 1'b0, 1'b0, ERR_NEWLINE);
            n  = 2'd1;
          end else if (c == CH_BACKSLASH) begin
            mode_nxt = M_ESC;
          end else if (c == CH_DQUOTE) begin
            mode_nxt = M_IDLE;
            r0 = mk_res(c, 1'b0, 1'b1, 1'b1, ERR_NONE);
            n  = 2'd1;
          end else begin
            r0 = mk_res(c, 1'b0, 1'b0, 1'b1, ERR_NONE);
            n  = 2'd1;
          end
        end
        M_ESC: begin
          if (c == CH_LF || !dec[8]) begin
            mode_nxt       = M_HALT;
            held_valid_nxt = 1'b0;
            r0 = mk_res(8'd0, 1'b0, 1'b0, 1'b0,
                        (c == CH_LF) ? ERR_NEWLINE : ERR_BAD_ESCAPE);
          end else begin
            mode_nxt = M_QUOTE;
            r0 = mk_res(dec[7:0], 1'b0, 1'b0, 1'b1, ERR_NONE);
          end
          n = 2'd1;
        end
        default: begin
          r0 = sc_res;
          n  = sc_emit ? 2'd1 : 2'd0;
          mode_nxt       = sc_mode;
          if (sc_hold) begin
            held_byte_nxt  = c;
            held_valid_nxt = 1'b1;
            held_first_nxt = 1'b1;
          end
        end
      endcase
    end

    if (n == 2'd1) r0.run_last = 1'b1;
    if (n == 2'd2) r1.run_last = 1'b1;
  end

  assign push           = accept && (n != 2'd0);
  assign push_plan.two  = (n == 2'd2);
  assign push_plan.r0   = r0;
  assign push_plan.r1   = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      held_first_r <= held_first_nxt;
    end
  end

endmodule

// ----- rtl/core/sft_queue.sv -----
// Small FIFO of result plans between the front end and the back end.
module sft_queue
  import sft_pkg::*;
#(
  parameter int unsigned QDEPTH = Q_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  plan_t     push_plan,
  input  logic      pop,
  output plan_t     head_plan,
  output q_status_t q_stat
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);

  plan_t         mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_plan    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_plan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/sft_back.sv -----
// Back end: unrolls each plan into one or two results and drives the output register.
module sft_back
  import sft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  plan_t     head_plan,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      sec_valid_r;
  out_item_t sec_r;
  logic      load;

  assign load      = !out_valid_r || !out_stall;
  // The second result of a plan goes out before the next plan is taken.
  assign pop       = load && !sec_valid_r && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (load) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= head_plan.two;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid_r) begin
        out_data_r <= sec_r;
      end else if (!q_stat.empty) begin
        out_data_r <= head_plan.r0;
        sec_r      <= head_plan.r1;
      end
    end
  end

endmodule

// ----- rtl/core/scene_file_tokenizer_core.sv -----
// Scene file tokenizer: top level joining front end, plan queue and back end.
//
// Takes one character per request and returns token bytes with first and last
// marks, skipping whitespace and '#' comments, decoding escapes inside quoted
// strings and reporting errors that halt the block until reset. A character is
// accepted every cycle while the plan queue (QDEPTH entries) has room; each
// request leaves zero, one or two results, and the back end delivers one result
// per cycle while out_stall is low, the second result of a request going out
// before the results of the next. A result passes through a queue entry and then
// the output register. Word bytes are held back one character, so the last byte
// of a word appears with the character that ends it.
module scene_file_tokenizer_core
  import sft_pkg::*;
#(
  parameter int unsigned QDEPTH = Q_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      push, pop;
  plan_t     push_plan, head_plan;
  q_status_t q_stat;

  sft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_plan (push_plan)
  );

  sft_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (push_plan),
    .pop       (pop),
    .head_plan (head_plan),
    .q_stat    (q_stat)
  );

  sft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_plan (head_plan),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb_scene_file_tokenizer_core.sv -----
// Self-checking testbench for the scene file tokenizer core, with a built-in lexer predictor.
module tb_scene_file_tokenizer_core;
  import sft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_COMMENT,
    LX_WORD,
    LX_QUOTE,
    LX_ESC,
    LX_HALT
  } lex_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predictor state.
  lex_mode_t  lex_state = LX_IDLE;
  logic [7:0] word_byte = 8'h00;
  logic       word_pending = 1'b0;
  logic       word_first = 1'b0;
  out_item_t  step_tokens[$];
  out_item_t  pending_tokens[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int tokens_checked = 0;
  int failures = 0;
  logic [2:0] halt_code = ERR_NONE;

  scene_file_tokenizer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit ends_word(input logic [7:0] c);
    return is_blank(c) || c == CH_DQUOTE || c == CH_LBRACKET || c == CH_RBRACKET;
  endfunction

  function automatic bit esc_lookup(input logic [7:0] c, output logic [7:0] v);
    v = c;
    case (c)
      CH_LOW_B: v = CH_BS;
      CH_LOW_F: v = CH_FF;
      CH_LOW_N: v = CH_LF;
      CH_LOW_R: v = CH_CR;
      CH_LOW_T: v = CH_TAB;
      CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE: v = c;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void emit_token(input logic [7:0] b, input logic f, input logic l,
                                     input logic v, input logic [2:0] e);
    out_item_t t;
    t.tok_byte    = b;
    t.token_first = f;
    t.token_last  = l;
    t.byte_valid  = v;
    t.error_code  = e;
    t.run_last    = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic void halt_with(input logic [2:0] code);
    lex_state    = LX_HALT;
    word_pending = 1'b0;
    emit_token(8'h00, 1'b0, 1'b0, 1'b0, code);
  endfunction

  function automatic void begin_token(input logic [7:0] c);
    if (is_blank(c)) begin
      return;
    end
    if (c == CH_DQUOTE) begin
      lex_state = LX_QUOTE;
      emit_token(c, 1'b1, 1'b0, 1'b1, ERR_NONE);
    end else if (c == CH_LBRACKET || c == CH_RBRACKET) begin
      emit_token(c, 1'b1, 1'b1, 1'b1, ERR_NONE);
    end else if (c == CH_HASH) begin
      lex_state = LX_COMMENT;
    end else begin
      lex_state    = LX_WORD;
      word_byte    = c;
      word_pending = 1'b1;
      word_first   = 1'b1;
    end
  endfunction

  // Advances the lexer by one accepted request and queues the token results it yields.
  function automatic void tokenize(input in_item_t it);
    logic [7:0] c;
    logic [7:0] dv;
    out_item_t  t;
    c = it.in_byte;
    step_tokens.delete();
    if (lex_state == LX_HALT) begin
      return;
    end
    if (it.end_of_input) begin
      if (lex_state == LX_QUOTE) begin
        halt_with(ERR_UNTERMINATED);
      end else if (lex_state == LX_ESC) begin
        halt_with(ERR_TRAIL_ESCAPE);
      end else begin
        if (lex_state == LX_WORD && word_pending) begin
          emit_token(word_byte, word_first, 1'b1, 1'b1, ERR_NONE);
        end
        lex_state    = LX_IDLE;
        word_pending = 1'b0;
        word_first   = 1'b0;
      end
    end else begin
      case (lex_state)
        LX_COMMENT: begin
          if (c == CH_CR || c == CH_LF) begin
            lex_state = LX_IDLE;
          end
        end
        LX_WORD: begin
          if (ends_word(c)) begin
            if (word_pending) begin
              emit_token(word_byte, word_first, 1'b1, 1'b1, ERR_NONE);
            end
            word_pending = 1'b0;
            word_first   = 1'b0;
            lex_state    = LX_IDLE;
            begin_token(c);
          end else begin
            if (word_pending) begin
              emit_token(word_byte, word_first, 1'b0, 1'b1, ERR_NONE);
            end
            word_byte    = c;
            word_pending = 1'b1;
            word_first   = 1'b0;
          end
        end
        LX_QUOTE: begin
          if (c == CH_LF) begin
            halt_with(ERR_NEWLINE);
          end else if (c == CH_BACKSLASH) begin
            lex_state = LX_ESC;
          end else if (c == CH_DQUOTE) begin
            lex_state = LX_IDLE;
            emit_token(c, 1'b0, 1'b1, 1'b1, ERR_NONE);
          end else begin
            emit_token(c, 1'b0, 1'b0, 1'b1, ERR_NONE);
          end
        end
        LX_ESC: begin
          if (c == CH_LF) begin
            halt_with(ERR_NEWLINE);
          end else if (!esc_lookup(c, dv)) begin
            halt_with(ERR_BAD_ESCAPE);
          end else begin
            lex_state = LX_QUOTE;
            emit_token(dv, 1'b0, 1'b0, 1'b1, ERR_NONE);
          end
        end
        default: begin
          lex_state = LX_IDLE;
          begin_token(c);
        end
      endcase
    end
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.run_last = (i == step_tokens.size() - 1);
      pending_tokens.insert(pending_tokens.size(), t);
    end
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 7))
      0: return CH_LOW_B;
      1: return CH_LOW_F;
      2: return CH_LOW_N;
      3: return CH_LOW_R;
      4: return CH_LOW_T;
      5: return CH_BACKSLASH;
      6: return CH_SQUOTE;
      default: return CH_DQUOTE;
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    in_item_t req;
    req.in_byte      = b;
    req.end_of_input = eoi;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    tokenize(req);
    items_sent++;
  endtask

  // Steers random characters away from the halting errors, which are saved for the end.
  task automatic send_random(input logic [7:0] b, input logic eoi);
    logic [7:0] dv;
    if (eoi && lex_state == LX_QUOTE) begin
      b   = CH_DQUOTE;
      eoi = 1'b0;
    end else if (eoi && lex_state == LX_ESC) begin
      b   = pick_escape();
      eoi = 1'b0;
    end else if (!eoi && lex_state == LX_QUOTE && b == CH_LF) begin
      b = CH_CR;
    end else if (!eoi && lex_state == LX_ESC && !esc_lookup(b, dv)) begin
      b = pick_escape();
    end
    send_item(b, eoi);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        failures++;
        if (failures <= 20) begin
          $display("%0t: unexpected result byte=%02h valid=%0b err=%0d, nothing pending",
                   $time, out_data.tok_byte, out_data.byte_valid, out_data.error_code);
        end
      end else begin
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (out_data.tok_byte !== want.tok_byte || out_data.token_first !== want.token_first ||
            out_data.token_last !== want.token_last || out_data.byte_valid !== want.byte_valid ||
            out_data.error_code !== want.error_code || out_data.run_last !== want.run_last) begin
          failures++;
          if (failures <= 20) begin
            $display("%0t: mismatch expected byte=%02h first=%0b last=%0b valid=%0b err=%0d rl=%0b",
                     $time, want.tok_byte, want.token_first, want.token_last, want.byte_valid,
                     want.error_code, want.run_last);
            $display("%0t:          actual   byte=%02h first=%0b last=%0b valid=%0b err=%0d rl=%0b",
                     $time, out_data.tok_byte, out_data.token_first, out_data.token_last,
                     out_data.byte_valid, out_data.error_code, out_data.run_last);
          end
        end
      end
    end
  end

  // Words with extreme byte values, '#' inside a word, brackets ending a word, and a comment.
  task automatic test_words_and_comments();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_HASH, 1'b0);
    send_item(CH_LBRACKET, 1'b0);
    send_item(CH_RBRACKET, 1'b0);
    send_item(CH_HASH, 1'b0);
    send_item("z", 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // A word ended by a quote, then every escape, a CR inside the string and the closing quote.
  task automatic test_quoted_escapes();
    logic [7:0] escapes[8];
    escapes = '{CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T,
                CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE};
    send_item("q", 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    foreach (escapes[i]) begin
      send_item(CH_BACKSLASH, 1'b0);
      send_item(escapes[i], 1'b0);
    end
    send_item(CH_CR, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item(8'h00, 1'b1);
    drain_results();
  endtask

  // Mostly well-formed tokens with random content, mixed with raw noise and end marks.
  task automatic test_random_text(input int send_pct, input int recv_pct, input int count);
    int stop_at;
    logic [7:0] b;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 8)) begin
            b = 8'($urandom_range(0, 255));
            if (ends_word(b)) begin
              b = 8'("a" + $urandom_range(0, 25));
            end
            send_random(b, 1'b0);
          end
        end
        3, 4: begin
          send_random(CH_DQUOTE, 1'b0);
          repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 3) == 0) begin
              send_random(CH_BACKSLASH, 1'b0);
              send_random(pick_escape(), 1'b0);
            end else begin
              send_random(8'($urandom_range(0, 255)), 1'b0);
            end
          end
          send_random(CH_DQUOTE, 1'b0);
        end
        5: send_random($urandom_range(0, 1) ? CH_LBRACKET : CH_RBRACKET, 1'b0);
        6: begin
          repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(0, 5));
            send_random((b == 5) ? CH_SPACE : CH_TAB + b, 1'b0);
          end
        end
        7: begin
          send_random(CH_HASH, 1'b0);
          repeat ($urandom_range(0, 5)) begin
            send_random(8'($urandom_range(0, 255)), 1'b0);
          end
          send_random($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
        end
        8: send_random(8'($urandom_range(0, 255)), 1'b1);
        default: begin
          repeat ($urandom_range(1, 4)) begin
            send_random(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
          end
        end
      endcase
    end
    drain_results();
  endtask

  // One randomly chosen error, then a few requests that the halted block must ignore.
  task automatic test_error_halt();
    logic [7:0] b;
    logic [7:0] dv;
    while (lex_state != LX_IDLE) begin
      send_random(8'($urandom_range(0, 255)), 1'b1);
    end
    halt_code = 3'($urandom_range(ERR_BAD_ESCAPE, ERR_UNTERMINATED));
    send_item(CH_DQUOTE, 1'b0);
    case (halt_code)
      ERR_BAD_ESCAPE: begin
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == CH_LF || esc_lookup(b, dv));
        send_item(CH_BACKSLASH, 1'b0);
        send_item(b, 1'b0);
      end
      ERR_NEWLINE: begin
        if ($urandom_range(0, 1)) begin
          send_item(CH_BACKSLASH, 1'b0);
        end
        send_item(CH_LF, 1'b0);
      end
      ERR_TRAIL_ESCAPE: begin
        send_item(CH_BACKSLASH, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        send_item("a", 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    repeat (6) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 9;
    recv_idle_pct = 72;
    test_words_and_comments();
    test_quoted_escapes();
    test_random_text(9, 72, 480);
    test_random_text(72, 9, 480);
    test_random_text(0, 0, 480);
    test_error_halt();
    repeat (20) @(posedge clk);
    $display("Lexed %0d requests across three idle patterns and checked %0d token results.",
             items_sent, tokens_checked);
    $display("Ended with halting error code %0d; %0d mismatches seen.", halt_code, failures);
    if (failures == 0 && pending_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
